// ===== hw/rtl/cssd_pkg.sv =====
// Shared types, constants and byte-class helpers for the CSS escape decoder.
package cssd_pkg;

  localparam logic [7:0]  BackSlash = 8'h5C;
  localparam logic [7:0]  NewLine   = 8'h0A;
  localparam logic [7:0]  FwLimit   = 8'h5F;
  localparam logic [7:0]  FwOffset  = 8'h20;
  localparam logic [15:0] FwPrefix  = 16'h00FF;
  localparam logic [2:0]  MaxDigits = 3'd6;
  localparam logic [2:0]  FwMinDigits = 3'd4;
  localparam int          QueueDepth = 4;
  localparam int          QueuePtrBits = $clog2(QueueDepth);

  typedef enum logic [2:0] {
    MODE_NORMAL = 3'b001,
    MODE_ESCAPE = 3'b010,
    MODE_HEX    = 3'b100
  } mode_t;

  // One accepted byte's worth of results, oldest first: hex byte, plain byte, terminator.
  typedef struct packed {
    logic        hex_v;
    logic [7:0]  hex_byte;
    logic        plain_v;
    logic [7:0]  plain_byte;
    logic        term_v;
    logic [15:0] count;
  } entry_t;

  function automatic logic is_hex(input logic [7:0] b);
    case (b) inside
      [8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]: is_hex = 1'b1;
      default: is_hex = 1'b0;
    endcase
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] b);
    case (b) inside
      [8'h30:8'h39]: hex_val = b[3:0];
      [8'h41:8'h46], [8'h61:8'h66]: hex_val = b[3:0] + 4'd9;
      default: hex_val = 4'h0;
    endcase
  endfunction

  function automatic logic is_space(input logic [7:0] b);
    case (b) inside
      8'h20, [8'h09:8'h0D]: is_space = 1'b1;
      default: is_space = 1'b0;
    endcase
  endfunction

  // Value of a completed escape; fullwidth FFxx forms shift 0x01..0x5E up by 0x20.
  function automatic logic [7:0] hex_finish(input logic [23:0] nib, input logic [2:0] cnt);
    logic [7:0] v;
    if (cnt <= 3'd1) begin
      v = {4'h0, nib[3:0]};
    end else begin
      v = nib[7:0];
      if (cnt >= FwMinDigits && nib[23:8] == FwPrefix && v != 8'h00 && v < FwLimit) begin
        v = v + FwOffset;
      end
    end
    hex_finish = v;
  endfunction

endpackage

// ===== hw/rtl/cssd_front.sv =====
// Front end: accepts bytes, runs the escape scanner and builds result entries.
module cssd_front import cssd_pkg::*; #(
  parameter int COUNT_BITS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [7:0] in_byte,
  input  logic       in_last_byte,
  input  logic       q_full,
  output logic       in_stall,
  output logic       push,
  output entry_t     push_entry
);

  localparam logic [COUNT_BITS+1:0] CountMax = {2'b00, {COUNT_BITS{1'b1}}};

  mode_t                 mode_r, mode_nxt;
  logic [23:0]           nib_r, nib_nxt;
  logic [2:0]            dc_r, dc_nxt;
  logic [COUNT_BITS-1:0] cnt_r, cnt_nxt;

  logic                  accept;
  logic                  b_hex;
  logic [3:0]            b_val;
  logic                  fin_now;
  logic [23:0]           fin_nib;
  logic [2:0]            fin_dc;
  logic                  hex_e, plain_e, term_e;
  logic [COUNT_BITS+1:0] cnt_sum;
  logic [COUNT_BITS-1:0] cnt_new;
  logic [31:0]           cnt_ext;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign b_hex    = is_hex(in_byte);
  assign b_val    = hex_val(in_byte);

  always_comb begin
    mode_nxt = mode_r;
    nib_nxt  = nib_r;
    dc_nxt   = dc_r;
    fin_now  = 1'b0;
    hex_e    = 1'b0;
    plain_e  = 1'b0;
    term_e   = 1'b0;
    case (mode_r)
      MODE_ESCAPE: begin
        mode_nxt = MODE_NORMAL;
        if (b_hex) begin
          mode_nxt = MODE_HEX;
          nib_nxt  = {20'h0, b_val};
          dc_nxt   = 3'd1;
        end else if (in_byte != NewLine) begin
          plain_e = 1'b1;
        end
      end
      MODE_HEX: begin
        if (b_hex && dc_r < MaxDigits) begin
          nib_nxt = {nib_r[19:0], b_val};
          dc_nxt  = dc_r + 3'd1;
        end else begin
          fin_now  = 1'b1;
          hex_e    = 1'b1;
          nib_nxt  = '0;
          dc_nxt   = '0;
          mode_nxt = MODE_NORMAL;
          if (!is_space(in_byte)) begin
            if (in_byte == BackSlash) mode_nxt = MODE_ESCAPE;
            else plain_e = 1'b1;
          end
        end
      end
      default: begin
        mode_nxt = MODE_NORMAL;
        if (in_byte == BackSlash) mode_nxt = MODE_ESCAPE;
        else plain_e = 1'b1;
      end
    endcase

    // escape still open at end of string is closed with what was collected
    if (in_last_byte) begin
      term_e = 1'b1;
      if (mode_nxt == MODE_HEX) hex_e = 1'b1;
    end
  end

  assign fin_nib = fin_now ? nib_r : nib_nxt;
  assign fin_dc  = fin_now ? dc_r  : dc_nxt;

  always_comb begin
    cnt_sum = {2'b00, cnt_r} + {{(COUNT_BITS+1){1'b0}}, hex_e} +
              {{(COUNT_BITS+1){1'b0}}, plain_e};
    cnt_new = (cnt_sum > CountMax) ? {COUNT_BITS{1'b1}} : cnt_sum[COUNT_BITS-1:0];
    cnt_ext = 32'(cnt_new);
  end

  always_comb begin
    push_entry.hex_v      = hex_e;
    push_entry.hex_byte   = hex_finish(fin_nib, fin_dc);
    push_entry.plain_v    = plain_e;
    push_entry.plain_byte = in_byte;
    push_entry.term_v     = term_e;
    push_entry.count      = (cnt_ext > 32'h0000_FFFF) ? 16'hFFFF : cnt_ext[15:0];
  end

  assign push = accept && (hex_e || plain_e || term_e);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_NORMAL;
      nib_r  <= '0;
      dc_r   <= '0;
      cnt_r  <= '0;
    end else if (accept) begin
      if (in_last_byte) begin
        mode_r <= MODE_NORMAL;
        nib_r  <= '0;
        dc_r   <= '0;
        cnt_r  <= '0;
      end else begin
        mode_r <= mode_nxt;
        nib_r  <= nib_nxt;
        dc_r   <= dc_nxt;
        cnt_r  <= cnt_new;
      end
    end
  end

endmodule

// ===== hw/rtl/cssd_queue.sv =====
// Small FIFO of result entries between the scanner and the output side.
module cssd_queue import cssd_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  entry_t push_entry,
  input  logic   pop,
  output logic   full,
  output logic   empty,
  output entry_t head
);

  entry_t                  mem [QueueDepth];
  logic [QueuePtrBits-1:0] wr_r, rd_r;
  logic [QueuePtrBits:0]   fill_r;

  assign full  = (fill_r == (QueuePtrBits+1)'(QueueDepth));
  assign empty = (fill_r == '0);
  assign head  = mem[rd_r];

  always_ff @(posedge clk) begin
    if (push) mem[wr_r] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r   <= '0;
      rd_r   <= '0;
      fill_r <= '0;
    end else begin
      if (push) wr_r <= wr_r + 1'b1;
      if (pop)  rd_r <= rd_r + 1'b1;
      if (push && !pop)      fill_r <= fill_r + 1'b1;
      else if (pop && !push) fill_r <= fill_r - 1'b1;
    end
  end

endmodule

// ===== hw/rtl/cssd_back.sv =====
// Back end: serializes each queued entry into result transfers through an output register.
module cssd_back import cssd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_empty,
  input  entry_t      head,
  output logic        pop,
  input  logic        out_stall,
  output logic        out_valid,
  output logic [7:0]  out_byte,
  output logic        out_end_of_string,
  output logic [15:0] out_byte_count
);

  logic [2:0]  done_r, done_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  byte_r, byte_nxt;
  logic        eos_r, eos_nxt;
  logic [15:0] count_r, count_nxt;
  logic [2:0]  rem, sel;
  logic        load;

  assign load = !out_valid_r || !out_stall;
  assign rem  = {head.term_v, head.plain_v, head.hex_v} & ~done_r;

  always_comb begin
    if (rem[0])      sel = 3'b001;
    else if (rem[1]) sel = 3'b010;
    else             sel = 3'b100;
  end

  always_comb begin
    done_nxt      = done_r;
    out_valid_nxt = out_valid_r;
    byte_nxt      = byte_r;
    eos_nxt       = eos_r;
    count_nxt     = count_r;
    pop           = 1'b0;
    if (load) begin
      out_valid_nxt = !q_empty;
      if (!q_empty) begin
        case (sel)
          3'b001: begin
            byte_nxt  = head.hex_byte;
            eos_nxt   = 1'b0;
            count_nxt = '0;
          end
          3'b010: begin
            byte_nxt  = head.plain_byte;
            eos_nxt   = 1'b0;
            count_nxt = '0;
          end
          default: begin
            byte_nxt  = '0;
            eos_nxt   = 1'b1;
            count_nxt = head.count;
          end
        endcase
        if ((rem & ~sel) == 3'b000) begin
          pop      = 1'b1;
          done_nxt = '0;
        end else begin
          done_nxt = done_r | sel;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      done_r      <= done_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r  <= byte_nxt;
    eos_r   <= eos_nxt;
    count_r <= count_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_byte          = byte_r;
  assign out_end_of_string = eos_r;
  assign out_byte_count    = count_r;

endmodule

// ===== hw/rtl/css_escape_decoder_core.sv =====
// Top level of the CSS backslash-escape decoder.
//
// Input channel (in_valid/in_stall): one raw byte per transfer, in_last_byte
// marks the final byte of a string. Output channel (out_valid/out_stall): one
// decoded byte per transfer; after the last byte of a string a terminator
// transfer follows with out_end_of_string set, out_byte zero and
// out_byte_count holding the decoded byte count (saturating).
// A byte is accepted every cycle while the entry queue has room. The scanner
// turns each byte into 0 to 3 results in the same cycle; the output side
// sends one result per cycle while out_stall is low, so bytes that give one
// result sustain one per cycle and bytes that give two or three are sent as
// that many transfers. An input byte's first result passes through the queue
// write and then the output register. When out_stall is high, the output
// register holds its result, the 4-entry queue fills, and then in_stall rises.
// Synchronous active-low reset returns the scanner to plain copying, clears
// the count and empties the queue and output register.
module css_escape_decoder_core import cssd_pkg::*; #(
  parameter int COUNT_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        out_end_of_string,
  output logic [15:0] out_byte_count
);

  logic   push, pop, q_full, q_empty;
  entry_t push_entry, head;

  cssd_front #(.COUNT_BITS(COUNT_BITS)) u_front (
    .clk, .rst_n, .in_valid, .in_byte, .in_last_byte,
    .q_full, .in_stall, .push, .push_entry
  );

  cssd_queue u_queue (
    .clk, .rst_n, .push, .push_entry, .pop,
    .full(q_full), .empty(q_empty), .head
  );

  cssd_back u_back (
    .clk, .rst_n, .q_empty, .head, .pop, .out_stall,
    .out_valid, .out_byte, .out_end_of_string, .out_byte_count
  );

endmodule

// ===== sim/css_escape_decoder_checker.sv =====
// Checker for the CSS escape decoder: predicts decoded bytes and terminators, compares outputs.
module css_escape_decoder_checker import cssd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_byte,
  input  logic        in_last_byte,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [7:0]  out_byte,
  input  logic        out_end_of_string,
  input  logic [15:0] out_byte_count,
  output int          mismatches,
  output int          outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0]  data;
    logic        eos;
    logic [15:0] count;
  } decoded_t;

  decoded_t    decoded_due[$];
  mode_t       mode;
  logic [23:0] nibbles;
  logic [2:0]  ndigits;
  logic [15:0] emitted;

  initial begin
    mismatches  = 0;
    outstanding = 0;
    mode        = MODE_NORMAL;
    nibbles     = '0;
    ndigits     = '0;
    emitted     = '0;
  end

  // {is_digit, value}
  function automatic logic [4:0] nibble_of(input logic [7:0] b);
    if (b >= 8'h30 && b <= 8'h39) return {1'b1, b[3:0]};
    if ((b >= 8'h41 && b <= 8'h46) || (b >= 8'h61 && b <= 8'h66)) return {1'b1, b[3:0] + 4'd9};
    return 5'd0;
  endfunction

  function automatic logic blank(input logic [7:0] b);
    return b == 8'h20 || (b >= 8'h09 && b <= 8'h0D);
  endfunction

  task automatic put_byte(input logic [7:0] b);
    decoded_due.push_back('{data: b, eos: 1'b0, count: 16'h0000});
    if (emitted != 16'hFFFF) emitted = emitted + 16'd1;
  endtask

  task automatic close_escape();
    logic [7:0] v;
    if (ndigits <= 3'd1) begin
      v = {4'h0, nibbles[3:0]};
    end else begin
      v = nibbles[7:0];
      // fullwidth form: digits ahead of the last two read FF
      if (ndigits >= FwMinDigits && nibbles[23:8] == FwPrefix && v != 8'h00 && v < FwLimit) begin
        v = v + FwOffset;
      end
    end
    put_byte(v);
    nibbles = '0;
    ndigits = '0;
    mode    = MODE_NORMAL;
  endtask

  task automatic copy_byte(input logic [7:0] b);
    if (b == BackSlash) mode = MODE_ESCAPE;
    else put_byte(b);
  endtask

  task automatic decode_step(input logic [7:0] b, input logic last);
    logic [4:0] nib;
    nib = nibble_of(b);
    case (mode)
      MODE_ESCAPE: begin
        mode = MODE_NORMAL;
        if (nib[4]) begin
          mode    = MODE_HEX;
          nibbles = {20'h0, nib[3:0]};
          ndigits = 3'd1;
        end else if (b != NewLine) begin
          put_byte(b);
        end
      end
      MODE_HEX: begin
        if (nib[4] && ndigits < MaxDigits) begin
          nibbles = {nibbles[19:0], nib[3:0]};
          ndigits = ndigits + 3'd1;
        end else begin
          close_escape();
          if (!blank(b)) copy_byte(b);
        end
      end
      default: begin
        mode = MODE_NORMAL;
        copy_byte(b);
      end
    endcase
    if (last) begin
      if (mode == MODE_HEX) close_escape();
      decoded_due.push_back('{data: 8'h00, eos: 1'b1, count: emitted});
      mode    = MODE_NORMAL;
      nibbles = '0;
      ndigits = '0;
      emitted = '0;
    end
  endtask

  task automatic flag(input decoded_t want, input logic missing);
    mismatches++;
    if (mismatches <= 10) begin
      if (missing)
        $display("%t: unexpected transfer: byte %h eos %b count %0d", $realtime,
                 out_byte, out_end_of_string, out_byte_count);
      else
        $display("%t: mismatch: expected byte %h eos %b count %0d, got byte %h eos %b count %0d",
                 $realtime, want.data, want.eos, want.count,
                 out_byte, out_end_of_string, out_byte_count);
    end
  endtask

  always @(posedge clk) begin
    decoded_t want;
    if (rst_n) begin
      if (in_valid === 1'b1 && in_stall === 1'b0) decode_step(in_byte, in_last_byte);
      if (out_valid === 1'b1 && out_stall === 1'b0) begin
        if (decoded_due.size() == 0) begin
          flag('0, 1'b1);
        end else begin
          want = decoded_due.pop_front();
          if (out_byte !== want.data || out_end_of_string !== want.eos ||
              out_byte_count !== want.count) flag(want, 1'b0);
        end
      end
    end
    outstanding <= decoded_due.size();
  end

endmodule

// ===== sim/tb_css_escape_decoder_core.sv =====
// Testbench top for the CSS escape decoder: reset, stimulus, output stalls and verdict.
module tb_css_escape_decoder_core;
  import cssd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum int {STALL_NONE, STALL_RANDOM, STALL_EVERY4, STALL_HOLD} stall_pattern_t;
  typedef enum int {TOK_PLAIN, TOK_LINE_CONT, TOK_ESC_CHAR, TOK_HEX, TOK_FULLWIDTH,
                    TOK_ESC_ANY} token_kind_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_byte = 8'h00;
  logic        in_last_byte = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_byte;
  logic        out_end_of_string;
  logic [15:0] out_byte_count;
  int          mismatches;
  int          outstanding;

  logic [7:0]     str_q[$];
  int             burst_left = 0;
  int             bytes_sent = 0;
  int             seg_left = 0;
  stall_pattern_t pattern = STALL_NONE;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  css_escape_decoder_core u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_byte           (in_byte),
    .in_last_byte      (in_last_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_byte          (out_byte),
    .out_end_of_string (out_end_of_string),
    .out_byte_count    (out_byte_count)
  );

  css_escape_decoder_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_byte           (in_byte),
    .in_last_byte      (in_last_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_byte          (out_byte),
    .out_end_of_string (out_end_of_string),
    .out_byte_count    (out_byte_count),
    .mismatches        (mismatches),
    .outstanding       (outstanding)
  );

  // receiver stalls: segments of random length, each with its own pattern
  always @(posedge clk) begin
    if (seg_left == 0) begin
      seg_left <= $urandom_range(4, 48);
      pattern  <= stall_pattern_t'($urandom_range(0, 3));
    end else begin
      seg_left <= seg_left - 1;
    end
    case (pattern)
      STALL_NONE:   out_stall <= 1'b0;
      STALL_RANDOM: out_stall <= 1'($urandom_range(0, 1));
      STALL_EVERY4: out_stall <= (seg_left % 4 == 0);
      default:      out_stall <= (seg_left > 2);
    endcase
  end

  // one transfer; the sender may idle between bursts
  task automatic push_byte(input logic [7:0] b, input logic last);
    int gap;
    in_valid     <= 1'b1;
    in_byte      <= b;
    in_last_byte <= last;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    bytes_sent++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
  endtask

  task automatic send_string();
    int n;
    n = str_q.size();
    for (int i = 0; i < n; i++) push_byte(str_q[i], i == n - 1);
    str_q.delete();
  endtask

  task automatic queue_text(input string s);
    for (int i = 0; i < s.len(); i++) str_q.push_back(s[i]);
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return 8'h30 + n;
    return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + n - 8'd10;
  endfunction

  function automatic logic [7:0] blank_char();
    int pick;
    pick = $urandom_range(0, 5);
    return pick == 5 ? 8'h20 : 8'h09 + 8'(pick);
  endfunction

  // what follows a hex escape: nothing, whitespace, another digit or any byte
  task automatic add_trailer();
    case ($urandom_range(0, 3))
      1: str_q.push_back(blank_char());
      2: str_q.push_back(hex_char(4'($urandom_range(0, 15))));
      3: str_q.push_back(8'($urandom_range(0, 255)));
      default: ;
    endcase
  endtask

  task automatic add_token(input token_kind_t kind);
    logic [7:0] b;
    int         digits;
    case (kind)
      TOK_PLAIN: begin
        b = 8'($urandom_range(0, 255));
        str_q.push_back(b);
        if (b == BackSlash) str_q.push_back(8'($urandom_range(0, 255)));
      end
      TOK_LINE_CONT: begin
        str_q.push_back(BackSlash);
        str_q.push_back(NewLine);
      end
      TOK_ESC_CHAR: begin
        do b = 8'($urandom_range(0, 255)); while (b inside {[8'h30:8'h39], [8'h41:8'h46],
                                                           [8'h61:8'h66]});
        str_q.push_back(BackSlash);
        str_q.push_back(b);
      end
      TOK_HEX: begin
        digits = $urandom_range(1, 6);
        str_q.push_back(BackSlash);
        repeat (digits) str_q.push_back(hex_char(4'($urandom_range(0, 15))));
        add_trailer();
      end
      TOK_FULLWIDTH: begin
        digits = $urandom_range(4, 6);
        case ($urandom_range(0, 4))
          0: b = 8'h00;
          1: b = 8'h01;
          2: b = 8'h5E;
          3: b = 8'h5F;
          default: b = 8'($urandom_range(0, 255));
        endcase
        str_q.push_back(BackSlash);
        repeat (digits - 4) str_q.push_back(8'h30);
        str_q.push_back(hex_char(4'hF));
        str_q.push_back(hex_char(4'hF));
        str_q.push_back(hex_char(b[7:4]));
        str_q.push_back(hex_char(b[3:0]));
        add_trailer();
      end
      default: begin
        str_q.push_back(BackSlash);
        str_q.push_back(8'($urandom_range(0, 255)));
      end
    endcase
  endtask

  initial begin
    int target;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    queue_text("\\41 Z");
    send_string();
    str_q.push_back(8'h00);
    str_q.push_back(8'hFF);
    send_string();
    queue_text("\\\n\\q");
    send_string();
    queue_text("\\1234567");
    send_string();
    queue_text("\\");
    send_string();
    queue_text("\\a");
    send_string();
    queue_text("\\ff01");
    send_string();

    target = bytes_sent + 440;
    while (bytes_sent < target) begin
      if ($urandom_range(0, 4) == 0) begin
        // noise: raw bytes, heavy on backslashes
        repeat ($urandom_range(1, 12)) begin
          str_q.push_back($urandom_range(0, 3) == 0 ? BackSlash : 8'($urandom_range(0, 255)));
        end
      end else begin
        repeat ($urandom_range(1, 8)) add_token(token_kind_t'($urandom_range(0, 5)));
        if ($urandom_range(0, 7) == 0) str_q.push_back(BackSlash);
      end
      send_string();
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) $display("tb_css_escape_decoder_core OK");
    else $display("tb_css_escape_decoder_core NOT OK");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("tb_css_escape_decoder_core NOT OK");
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/cssd_pkg.sv
hw/rtl/cssd_front.sv
hw/rtl/cssd_queue.sv
hw/rtl/cssd_back.sv
hw/rtl/css_escape_decoder_core.sv
sim/css_escape_decoder_checker.sv
sim/tb_css_escape_decoder_core.sv
